### rtl/assert_macros.svh
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/fsfl_pkg.sv
// shared constants and types of the slot allocator
`timescale 1ns / 1ps
package fsfl_pkg;
	localparam int MAX_SLOTS = 1024;
	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int CNT_W = SLOT_W + 1;
	localparam logic [CNT_W-1:0] MAX_SLOTS_CNT = CNT_W'(MAX_SLOTS);

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_NO_SLOT = 2'd1,
		STATUS_FREE_ERR = 2'd2
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;
endpackage

### rtl/fsfl_ctrl.sv
// controller state machine and output valid of the slot allocator
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fsfl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output fsfl_pkg::cmd_t cmd
);
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// result register can take a new word
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && in_valid;
	assign cmd.exec = (state_q == ST_EXEC) && out_free;
	assign out_valid = out_valid_q;

	// state sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.exec) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	`ASSERT_NEXT(a_capture_to_exec, clk, arst_n, cmd.capture, state_q == ST_EXEC)
	`ASSERT_NEXT(a_exec_shows_word, clk, arst_n, cmd.exec, out_valid_q && state_q == ST_IDLE)
	`ASSERT_NEXT(a_blocked_waits, clk, arst_n,
		state_q == ST_EXEC && out_valid_q && out_stall, state_q == ST_EXEC)
endmodule

### rtl/fsfl_datapath.sv
// allocator state, link memory and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fsfl_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fsfl_pkg::cmd_t              cmd,
	input  logic                        cfg_valid,
	input  logic [fsfl_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        func,
	input  logic [fsfl_pkg::SLOT_W-1:0] slot_index,
	output logic [fsfl_pkg::SLOT_W-1:0] granted_slot,
	output logic [1:0]                  status,
	output logic                        is_full,
	output logic                        page_empty,
	output logic [fsfl_pkg::CNT_W-1:0]  used_now
);
	localparam int SW = fsfl_pkg::SLOT_W;
	localparam int CW = fsfl_pkg::CNT_W;

	// link memory: valid of the next entry and its slot
	logic [SW:0] link_mem [fsfl_pkg::MAX_SLOTS];
	logic [SW:0] link_rd_q;

	logic [CW-1:0] slot_total_q;
	logic [SW-1:0] head_q;
	logic          head_valid_q;
	logic [CW-1:0] bump_q;
	logic [CW-1:0] used_q;
	logic          func_q;
	logic [SW-1:0] slot_q;

	logic [SW-1:0] granted_slot_q;
	fsfl_pkg::status_t status_q;
	logic          is_full_q;
	logic          page_empty_q;
	logic [CW-1:0] used_now_q;

	logic [CW-1:0] eff_total;
	logic [SW-1:0] head_n;
	logic          head_valid_n;
	logic [CW-1:0] bump_n;
	logic [CW-1:0] used_n;
	logic [SW-1:0] granted_n;
	fsfl_pkg::status_t status_n;
	logic          push;

	// slot count above the store size acts as the store size
	assign eff_total = (slot_total_q > fsfl_pkg::MAX_SLOTS_CNT) ?
		fsfl_pkg::MAX_SLOTS_CNT : slot_total_q;

	// next state of one allocate or free
	always_comb begin
		head_n = head_q;
		head_valid_n = head_valid_q;
		bump_n = bump_q;
		used_n = used_q;
		granted_n = '0;
		status_n = fsfl_pkg::STATUS_OK;
		push = 1'b0;
		if (func_q == fsfl_pkg::FUNC_ALLOC) begin
			if (head_valid_q) begin
				granted_n = head_q;
				head_valid_n = link_rd_q[SW];
				head_n = link_rd_q[SW-1:0];
				used_n = used_q + CW'(1);
			end else if (bump_q < eff_total) begin
				granted_n = bump_q[SW-1:0];
				bump_n = bump_q + CW'(1);
				used_n = used_q + CW'(1);
			end else begin
				status_n = fsfl_pkg::STATUS_NO_SLOT;
			end
		end else begin
			if (used_q == '0) begin
				status_n = fsfl_pkg::STATUS_FREE_ERR;
			end else begin
				push = 1'b1;
				head_n = slot_q;
				head_valid_n = 1'b1;
				used_n = used_q - CW'(1);
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_total_q <= fsfl_pkg::MAX_SLOTS_CNT;
		end else if (cfg_valid) begin
			slot_total_q <= cfg_data;
		end
	end

	// allocator control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			head_valid_q <= 1'b0;
			bump_q <= '0;
			used_q <= '0;
		end else if (cmd.exec) begin
			head_q <= head_n;
			head_valid_q <= head_valid_n;
			bump_q <= bump_n;
			used_q <= used_n;
		end
	end

	// captured input word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			slot_q <= slot_index;
		end
	end

	// link memory: read at the head on capture, write on push
	always_ff @(posedge clk) begin
		if (cmd.exec && push) link_mem[slot_q] <= {head_valid_q, head_q};
		if (cmd.capture) link_rd_q <= link_mem[head_q];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			granted_slot_q <= granted_n;
			status_q <= status_n;
			is_full_q <= (used_n >= eff_total);
			page_empty_q <= (used_n == '0);
			used_now_q <= used_n;
		end
	end

	assign granted_slot = granted_slot_q;
	assign status = status_q;
	assign is_full = is_full_q;
	assign page_empty = page_empty_q;
	assign used_now = used_now_q;

	`ASSERT_ALWAYS(a_used_bounded, clk, arst_n, used_q <= fsfl_pkg::MAX_SLOTS_CNT)
	`ASSERT_ALWAYS(a_bump_bounded, clk, arst_n, bump_q <= fsfl_pkg::MAX_SLOTS_CNT)
	`ASSERT_ALWAYS(a_fail_only_when_dry, clk, arst_n,
		!(cmd.exec && status_n == fsfl_pkg::STATUS_NO_SLOT) || !head_valid_q)
endmodule

### rtl/fixed_slot_free_list_allocator_core.sv
// top level of the fixed slot free list allocator
//
// Input channel (in_valid / in_stall) carries one word: func selects allocate
// or free, slot_index names the slot to free. Output channel (out_valid /
// out_stall) returns one word per input word: granted_slot, status, is_full,
// page_empty and used_now, in input order. cfg_valid / cfg_ready writes the
// slot count (cfg_ready is always high); write it only while idle.
// Each word is captured, with a read of the link memory at the free list
// head, then state is updated and the result register loaded. The result
// word turns valid after that update step, which waits while the previous
// result is still held; no new input word is taken before the last has
// been through the update step, a split set by the synchronous link read.
// Reset empties the free list, clears the bump index and used count and sets
// the slot count to 1024; the link memory needs no clearing pass, as an
// entry is read only after it was written by a free.
// While the receiver stalls, the result word holds; the next input word is
// captured meanwhile and waits in the update step until the result is taken.
`timescale 1ns / 1ps
module fixed_slot_free_list_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fsfl_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [fsfl_pkg::SLOT_W-1:0] slot_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fsfl_pkg::SLOT_W-1:0] granted_slot,
	output logic [1:0]                  status,
	output logic                        is_full,
	output logic                        page_empty,
	output logic [fsfl_pkg::CNT_W-1:0]  used_now
);
	fsfl_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	fsfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	fsfl_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.func         (func),
		.slot_index   (slot_index),
		.granted_slot (granted_slot),
		.status       (status),
		.is_full      (is_full),
		.page_empty   (page_empty),
		.used_now     (used_now)
	);
endmodule
